// ===== sv/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Widths and latencies shared by the 3x3 matrix inverse block.
// ----------------------------------------------------------------------------
package mi3_pkg;

    // Field widths.
    localparam int W_IN    = 16;   // Q1.14 matrix entry
    localparam int W_PROD  = 32;   // product of two entries
    localparam int W_COF   = 33;   // cofactor, difference of two products
    localparam int W_DTERM = 49;   // entry times cofactor
    localparam int W_DET   = 48;   // determinant, Q5.42
    localparam int W_INV   = 32;   // inverse entry, Q17.14

    // Divider: one quotient bit per stage, plus a prepare and a finish stage.
    localparam int DIV_STEPS = W_INV;
    localparam int DIV_LAT   = DIV_STEPS + 2;

    // Stages ahead of the divider: products, cofactors, det terms, det sum.
    localparam int FRONT_LAT = 4;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT;

    typedef logic signed [W_IN-1:0]  t_entry;
    typedef logic signed [W_COF-1:0] t_cof;
    typedef logic signed [W_DET-1:0] t_det;
    typedef logic signed [W_INV-1:0] t_inv;

endpackage

// ===== sv/mi3_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_mat_if / mi3_inv_if
// Valid/ready channels carrying one matrix item and one inverse item.
// ----------------------------------------------------------------------------
interface mi3_mat_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_inv_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  inv00, inv01, inv02, inv10, inv11, inv12;
    logic signed [31:0]  inv20, inv21, inv22;
    logic signed [47:0]  determinant;
    logic                singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, determinant, singular, output ready);
endinterface

// ===== sv/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Determinant and adjugate inverse of a 3x3 Q1.14 matrix, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   i_mat carries one matrix item (nine Q1.14 entries). o_inv carries one
//   result item: nine Q17.14 saturated inverse entries, the exact Q5.42
//   determinant and a singular flag, which forces the entries to zero.
//   From acceptance to o_inv.valid an item passes four front stages (entry
//   products, cofactors, determinant terms, determinant sum) and a 34-stage
//   divider that settles one quotient bit per stage in nine lanes.
//   Throughput is one item per cycle. When the receiver holds ready low with
//   a result waiting, the whole pipeline freezes and i_mat.ready drops;
//   nothing is lost or repeated. Bubbles in flight are filled while stalled
//   only once the output is taken. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mi3_mat_if.sink   i_mat,
    mi3_inv_if.source o_inv
);
    import mi3_pkg::*;

    logic                 adv;
    logic [TOTAL_LAT-1:0] r_vld;

    t_entry                  m [9];
    logic signed [W_PROD-1:0] r_p  [18];
    t_entry                  r_m0_s1 [3];
    t_entry                  r_m0_s2 [3];
    t_cof                    r_cof_s2 [9];
    t_cof                    r_cof_s3 [9];
    t_cof                    r_cof_s4 [9];
    logic signed [W_DTERM-1:0] r_dt [3];
    t_det                    r_det;
    t_det                    r_det_dly [DIV_LAT];
    t_inv                    quo [9];
    logic signed [W_DTERM+1:0] dsum;

    // The pipeline moves whenever the output register is free or taken.
    assign adv         = !r_vld[TOTAL_LAT-1] || o_inv.ready;
    assign i_mat.ready = adv;

    always_comb begin
        m[0] = i_mat.a00; m[1] = i_mat.a01; m[2] = i_mat.a02;
        m[3] = i_mat.a10; m[4] = i_mat.a11; m[5] = i_mat.a12;
        m[6] = i_mat.a20; m[7] = i_mat.a21; m[8] = i_mat.a22;
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_mat.valid};
        end
    end

    // Stage 1: the eighteen entry products of the cofactors.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p[0]  <= m[4] * m[8]; r_p[1]  <= m[5] * m[7];
            r_p[2]  <= m[2] * m[7]; r_p[3]  <= m[1] * m[8];
            r_p[4]  <= m[1] * m[5]; r_p[5]  <= m[2] * m[4];
            r_p[6]  <= m[5] * m[6]; r_p[7]  <= m[3] * m[8];
            r_p[8]  <= m[0] * m[8]; r_p[9]  <= m[2] * m[6];
            r_p[10] <= m[2] * m[3]; r_p[11] <= m[0] * m[5];
            r_p[12] <= m[3] * m[7]; r_p[13] <= m[4] * m[6];
            r_p[14] <= m[1] * m[6]; r_p[15] <= m[0] * m[7];
            r_p[16] <= m[0] * m[4]; r_p[17] <= m[1] * m[3];
            r_m0_s1[0] <= m[0]; r_m0_s1[1] <= m[1]; r_m0_s1[2] <= m[2];
        end
    end

    // Stage 2: cofactors of the transposed matrix.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r_cof_s2[k] <= W_COF'(r_p[2*k]) - W_COF'(r_p[2*k+1]);
            end
            r_m0_s2 <= r_m0_s1;
        end
    end

    // Stage 3: first-row terms of the determinant.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dt[0]  <= r_m0_s2[0] * r_cof_s2[0];
            r_dt[1]  <= r_m0_s2[1] * r_cof_s2[3];
            r_dt[2]  <= r_m0_s2[2] * r_cof_s2[6];
            r_cof_s3 <= r_cof_s2;
        end
    end

    // Stage 4: determinant sum; its magnitude stays below 2^47.
    assign dsum = (W_DTERM+2)'(r_dt[0]) + (W_DTERM+2)'(r_dt[1]) + (W_DTERM+2)'(r_dt[2]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_det    <= dsum[W_DET-1:0];
            r_cof_s4 <= r_cof_s3;
        end
    end

    // Nine divider lanes.
    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_cof (r_cof_s4[k]),
            .i_det (r_det),
            .o_quo (quo[k])
        );
    end

    // The determinant follows the divider lanes.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_det_dly[0] <= r_det;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_det_dly[k] <= r_det_dly[k-1];
            end
        end
    end

    // Result item; a zero determinant forces the entries to zero.
    always_comb begin
        o_inv.valid       = r_vld[TOTAL_LAT-1];
        o_inv.determinant = r_det_dly[DIV_LAT-1];
        o_inv.singular    = (r_det_dly[DIV_LAT-1] == '0);
        o_inv.inv00 = o_inv.singular ? '0 : quo[0];
        o_inv.inv01 = o_inv.singular ? '0 : quo[1];
        o_inv.inv02 = o_inv.singular ? '0 : quo[2];
        o_inv.inv10 = o_inv.singular ? '0 : quo[3];
        o_inv.inv11 = o_inv.singular ? '0 : quo[4];
        o_inv.inv12 = o_inv.singular ? '0 : quo[5];
        o_inv.inv20 = o_inv.singular ? '0 : quo[6];
        o_inv.inv21 = o_inv.singular ? '0 : quo[7];
        o_inv.inv22 = o_inv.singular ? '0 : quo[8];
    end

    // A stall freezes every valid bit.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // An accepted item enters the first stage.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && i_mat.valid) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    // A singular result carries zero entries.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.singular) |-> (o_inv.inv00 == 0 && o_inv.inv11 == 0
            && o_inv.inv22 == 0))
        else $error("singular result with nonzero entries");

endmodule

// ===== sv/mi3_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// Pipelined signed divider: (cof * 2^28) / det, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module mi3_div (
    input  logic          i_clk,
    input  logic          i_en,
    input  mi3_pkg::t_cof i_cof,
    input  mi3_pkg::t_det i_det,
    output mi3_pkg::t_inv o_quo
);
    import mi3_pkg::*;

    logic [W_DET-1:0]     r_rem [DIV_STEPS+1];
    logic [W_DET-1:0]     r_dv  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic [3:0]           r_nl  [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    t_inv                 r_quo;

    logic [W_COF-1:0] cabs;
    logic [W_DET-1:0] dabs;

    // Magnitudes of both operands.
    always_comb begin
        cabs = i_cof[W_COF-1] ? W_COF'(-i_cof) : W_COF'(i_cof);
        dabs = i_det[W_DET-1] ? W_DET'(-i_det) : W_DET'(i_det);
    end

    // Prepare: the quotient overflows 32 bits unless |cof| < 16 * |det|.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= W_DET'(cabs[W_COF-1:4]);
            r_dv[0]  <= dabs;
            r_q[0]   <= '0;
            r_nl[0]  <= cabs[3:0];
            r_neg[0] <= i_cof[W_COF-1] ^ i_det[W_DET-1];
            r_ovf[0] <= !({19'd0, cabs} < {dabs, 4'd0});
        end
    end

    // One restoring step per stage; stage k settles quotient bit 31-k.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        logic           nbit;
        logic [W_DET:0] trial;
        logic [W_DET:0] diff;

        always_comb begin
            nbit  = (BIT >= 28) ? r_nl[k][(BIT >= 28) ? BIT - 28 : 0] : 1'b0;
            trial = {r_rem[k], nbit};
            diff  = trial - {1'b0, r_dv[k]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k+1]  <= r_dv[k];
                r_nl[k+1]  <= r_nl[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                if (!diff[W_DET]) begin
                    r_rem[k+1] <= diff[W_DET-1:0];
                    r_q[k+1]   <= r_q[k] | (DIV_STEPS'(1) << BIT);
                end else begin
                    r_rem[k+1] <= trial[W_DET-1:0];
                    r_q[k+1]   <= r_q[k];
                end
            end
        end
    end

    // Finish: apply the sign and clamp to the 32-bit range.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[DIV_STEPS]) begin
                if (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > 32'h8000_0000)) begin
                    r_quo <= 32'sh8000_0000;
                end else begin
                    r_quo <= t_inv'(-r_q[DIV_STEPS]);
                end
            end else begin
                if (r_ovf[DIV_STEPS] || r_q[DIV_STEPS][31]) begin
                    r_quo <= 32'sh7FFF_FFFF;
                end else begin
                    r_quo <= t_inv'(r_q[DIV_STEPS]);
                end
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives random and corner 3x3 matrices into matrix_inverse_3x3 and checks
// every determinant, singular flag and saturated inverse entry in order.
// ----------------------------------------------------------------------------
module tb;
    import mi3_pkg::*;

    typedef struct {
        logic signed [15:0] a [9];
    } t_matrix;

    typedef struct {
        logic signed [31:0] inv [9];
        logic signed [47:0] det;
        logic               sing;
    } t_inverse;

    // Holds the inverses predicted for accepted matrices, oldest first.
    class inverse_board;
        t_inverse pending [$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Computes the adjugate inverse of one accepted matrix.
        function void note_matrix(t_matrix mat);
            longint   m [9];
            longint   adj [9];
            longint   det;
            longint   q;
            t_inverse r;
            for (int i = 0; i < 9; i++) m[i] = mat.a[i];
            adj[0] = m[4] * m[8] - m[5] * m[7];
            adj[1] = m[2] * m[7] - m[1] * m[8];
            adj[2] = m[1] * m[5] - m[2] * m[4];
            adj[3] = m[5] * m[6] - m[3] * m[8];
            adj[4] = m[0] * m[8] - m[2] * m[6];
            adj[5] = m[2] * m[3] - m[0] * m[5];
            adj[6] = m[3] * m[7] - m[4] * m[6];
            adj[7] = m[1] * m[6] - m[0] * m[7];
            adj[8] = m[0] * m[4] - m[1] * m[3];
            det = m[0] * adj[0] + m[1] * adj[3] + m[2] * adj[6];
            r.sing = (det == 0);
            r.det  = r.sing ? 48'sd0 : det[47:0];
            for (int i = 0; i < 9; i++) begin
                if (r.sing) begin
                    r.inv[i] = 0;
                end else begin
                    q = (adj[i] * (64'sd1 <<< 28)) / det;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    r.inv[i] = q[31:0];
                end
            end
            pending.push_back(r);
        endfunction

        // Compares one accepted result with the oldest prediction.
        function void check_inverse(t_inverse got);
            t_inverse exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, det %0d", $time, got.det);
                errors++;
                return;
            end
            exp = pending.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.inv[i] !== exp.inv[i]) begin
                    $display("%0t: inv%0d%0d expected %0d actual %0d", $time,
                             i / 3, i % 3, exp.inv[i], got.inv[i]);
                    errors++;
                end
            if (got.det !== exp.det) begin
                $display("%0t: determinant expected %0d actual %0d", $time,
                         exp.det, got.det);
                errors++;
            end
            if (got.sing !== exp.sing) begin
                $display("%0t: singular expected %0b actual %0b", $time,
                         exp.sing, got.sing);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mi3_mat_if mat_ch ();
    mi3_inv_if inv_ch ();

    matrix_inverse_3x3 DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_ch.sink),
        .o_inv  (inv_ch.source)
    );

    inverse_board board = new();
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet     = 0;
    bit timed_out = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Sample both channels at the rising edge and run the watchdog.
    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n) begin
            if (mat_ch.valid && mat_ch.ready) begin
                t_matrix mat;
                mat.a = '{mat_ch.a00, mat_ch.a01, mat_ch.a02, mat_ch.a10,
                          mat_ch.a11, mat_ch.a12, mat_ch.a20, mat_ch.a21,
                          mat_ch.a22};
                board.note_matrix(mat);
            end
            if (inv_ch.valid && inv_ch.ready) begin
                got.inv = '{inv_ch.inv00, inv_ch.inv01, inv_ch.inv02,
                            inv_ch.inv10, inv_ch.inv11, inv_ch.inv12,
                            inv_ch.inv20, inv_ch.inv21, inv_ch.inv22};
                got.det  = inv_ch.determinant;
                got.sing = inv_ch.singular;
                board.check_inverse(got);
            end
            if ((mat_ch.valid && mat_ch.ready) || (inv_ch.valid && inv_ch.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
        end
    end

    always @(posedge i_clk) begin
        if (quiet >= 5000 && !timed_out) begin
            timed_out = 1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The receiver stalls at random on the falling edge.
    always @(negedge i_clk) begin
        inv_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one matrix and holds it until accepted. Valid stays high on
    // return so that the next item can follow without a gap.
    task automatic send_matrix(t_matrix mat);
        while ($urandom_range(99) < idle_pct) begin
            mat_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        mat_ch.valid <= 1'b1;
        {mat_ch.a00, mat_ch.a01, mat_ch.a02} <= {mat.a[0], mat.a[1], mat.a[2]};
        {mat_ch.a10, mat_ch.a11, mat_ch.a12} <= {mat.a[3], mat.a[4], mat.a[5]};
        {mat_ch.a20, mat_ch.a21, mat_ch.a22} <= {mat.a[6], mat.a[7], mat.a[8]};
        @(posedge i_clk);
        while (!mat_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic drain();
        mat_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    // Random matrix; some entries are forced to extremes or zero.
    function automatic t_matrix rand_matrix();
        t_matrix mat;
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 9; i++) begin
            case ($urandom_range(11))
                0: mat.a[i] = 16'sh7FFF;
                1: mat.a[i] = 16'sh8000;
                2: mat.a[i] = 0;
                3: mat.a[i] = $urandom_range(8) - 4;
                default: mat.a[i] = $urandom();
            endcase
        end
        // Near-singular or singular: copy a row, copy it with small offsets, or shrink every entry.
        if (kind == 0) begin
            for (int c = 0; c < 3; c++) mat.a[6 + c] = mat.a[c];
        end else if (kind == 1) begin
            for (int c = 0; c < 3; c++) mat.a[3 + c] = mat.a[c] + $urandom_range(2) - 1;
        end else if (kind == 2) begin
            for (int i = 0; i < 9; i++) mat.a[i] = $urandom_range(64) - 32;
        end
        return mat;
    endfunction

    initial begin
        t_matrix mat;
        i_rst_n      = 1'b0;
        mat_ch.valid = 1'b0;
        inv_ch.ready = 1'b0;
        {mat_ch.a00, mat_ch.a01, mat_ch.a02, mat_ch.a10, mat_ch.a11,
         mat_ch.a12, mat_ch.a20, mat_ch.a21, mat_ch.a22} = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: identity, zero, extremes, scaled identity, saturation.
        mat.a = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
        send_matrix(mat);
        mat.a = '{default: 0};
        send_matrix(mat);
        mat.a = '{default: 16'sh7FFF};
        send_matrix(mat);
        mat.a = '{default: 16'sh8000};
        send_matrix(mat);
        mat.a = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
        send_matrix(mat);
        mat.a = '{16'sh7FFF, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh7FFF};
        send_matrix(mat);
        mat.a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(mat);
        mat.a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(mat);
        mat.a = '{0, 16'sd16384, 0, 0, 0, 16'sd16384, 16'sd16384, 0, 0};
        send_matrix(mat);
        mat.a = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
                  16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000};
        send_matrix(mat);
        mat.a = '{16'sh5555, -16'sh5555, 16'sh2AAA, 16'sh0F0F, 16'sh70F0,
                  -16'sh1234, 16'sh3C3C, 16'sh0001, -16'sh7FFF};
        send_matrix(mat);
        for (int i = 0; i < 4; i++) send_matrix(rand_matrix());

        // Random phases with different idling patterns.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                3: begin idle_pct = 18; stall_pct = 18; end
                default: begin idle_pct = $urandom_range(30); stall_pct = 0; end
            endcase
            for (int n = 0; n < 350; n++) begin
                if (n % 100 == 0 && $urandom_range(1))
                    drain();
                send_matrix(rand_matrix());
            end
            // Let everything drain between phases.
            drain();
        end

        stall_pct = 0;
        repeat (TOTAL_LAT + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
